### rtl/core/fcmac_pkg.sv
// Shared constants and types for the fully connected layer MAC.
package fcmac_pkg;

  localparam int unsigned DataW        = 32;
  localparam int unsigned WeightW      = 16;
  localparam int unsigned ProdW        = DataW + WeightW;
  localparam int unsigned AccW         = 64;
  localparam int unsigned NeuronW      = 6;
  localparam int unsigned InCountW     = 10;
  localparam int unsigned OutCountW    = 7;
  localparam int unsigned CfgDataW     = 10;
  localparam int unsigned CfgIdxW      = 1;
  localparam int unsigned InTdataW     = 64;
  localparam int unsigned OutTdataW    = 40;

  localparam int unsigned MaxInputsDef  = 512;
  localparam int unsigned MaxOutputsDef = 64;

  localparam logic [InCountW-1:0]  InCountRst  = InCountW'(400);
  localparam logic [OutCountW-1:0] OutCountRst = OutCountW'(64);

  localparam logic [CfgIdxW-1:0] RegInputCount  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegOutputCount = CfgIdxW'(1);

  localparam logic FuncLoad   = 1'b0;
  localparam logic FuncWeight = 1'b1;

  // Per-weight control that travels with the MAC pipeline
  typedef struct packed {
    logic               valid;
    logic               done;
    logic               last;
    logic [NeuronW-1:0] neuron;
  } mac_ctrl_t;

endpackage

### rtl/core/fcmac_act_mem.sv
// Activation store: one write port, one registered read port.
module fcmac_act_mem #(
  parameter int unsigned Depth = fcmac_pkg::MaxInputsDef,
  parameter int unsigned AddrW = 9
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [AddrW-1:0]             waddr_i,
  input  logic [fcmac_pkg::DataW-1:0]  wdata_i,
  input  logic                         re_i,
  input  logic [AddrW-1:0]             raddr_i,
  output logic [fcmac_pkg::DataW-1:0]  rdata_o
);

  logic [fcmac_pkg::DataW-1:0] mem_q [Depth];
  logic [fcmac_pkg::DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/fcmac_ctrl.sv
// Configuration registers and load, column and row position tracking.
module fcmac_ctrl #(
  parameter int unsigned MaxInputs  = fcmac_pkg::MaxInputsDef,
  parameter int unsigned MaxOutputs = fcmac_pkg::MaxOutputsDef,
  parameter int unsigned AddrW      = 9
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fcmac_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [fcmac_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                            accept_i,
  input  logic                            func_i,
  output logic                            mem_we_o,
  output logic [AddrW-1:0]                mem_waddr_o,
  output logic                            mem_re_o,
  output logic [AddrW-1:0]                mem_raddr_o,
  output fcmac_pkg::mac_ctrl_t            ctrl_o
);

  localparam int unsigned RowW = (MaxOutputs > 1) ? $clog2(MaxOutputs) : 1;
  localparam int unsigned ColCmpW =
      (fcmac_pkg::InCountW > AddrW + 1) ? fcmac_pkg::InCountW : AddrW + 1;
  localparam int unsigned RowCmpW =
      (fcmac_pkg::OutCountW > RowW + 1) ? fcmac_pkg::OutCountW : RowW + 1;

  logic [fcmac_pkg::InCountW-1:0]  in_count_q;
  logic [fcmac_pkg::OutCountW-1:0] out_count_q;
  logic [AddrW-1:0]   load_pos_q, load_pos_d;
  logic [AddrW-1:0]   col_q, col_d;
  logic [RowW-1:0]    row_q, row_d;
  logic [ColCmpW-1:0] load_inc, col_inc;
  logic [RowCmpW-1:0] row_inc;
  logic               load_wrap, col_done, row_last;
  logic               is_load, is_weight;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_count_q  <= fcmac_pkg::InCountRst;
      out_count_q <= fcmac_pkg::OutCountRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fcmac_pkg::RegInputCount:  in_count_q  <= cfg_data_i[fcmac_pkg::InCountW-1:0];
        fcmac_pkg::RegOutputCount: out_count_q <= cfg_data_i[fcmac_pkg::OutCountW-1:0];
        default: ;
      endcase
    end
  end

  assign is_load   = accept_i && (func_i == fcmac_pkg::FuncLoad);
  assign is_weight = accept_i && (func_i == fcmac_pkg::FuncWeight);

  // Counts of zero act as one, counts above the maximum act as the maximum
  assign load_inc  = ColCmpW'(load_pos_q) + ColCmpW'(1);
  assign load_wrap = (load_inc >= ColCmpW'(in_count_q)) || (load_inc == ColCmpW'(MaxInputs));
  assign col_inc   = ColCmpW'(col_q) + ColCmpW'(1);
  assign col_done  = (col_inc >= ColCmpW'(in_count_q)) || (col_inc == ColCmpW'(MaxInputs));
  assign row_inc   = RowCmpW'(row_q) + RowCmpW'(1);
  assign row_last  = (row_inc >= RowCmpW'(out_count_q)) || (row_inc == RowCmpW'(MaxOutputs));

  always_comb begin
    load_pos_d = load_pos_q;
    col_d      = col_q;
    row_d      = row_q;
    if (is_load) begin
      load_pos_d = load_wrap ? '0 : load_inc[AddrW-1:0];
    end
    if (is_weight) begin
      col_d = col_done ? '0 : col_inc[AddrW-1:0];
      if (col_done) begin
        row_d = row_last ? '0 : row_inc[RowW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_pos_q <= '0;
      col_q      <= '0;
      row_q      <= '0;
    end else begin
      load_pos_q <= load_pos_d;
      col_q      <= col_d;
      row_q      <= row_d;
    end
  end

  assign mem_we_o    = is_load;
  assign mem_waddr_o = load_pos_q;
  assign mem_re_o    = is_weight;
  assign mem_raddr_o = col_q;

  assign ctrl_o.valid  = is_weight;
  assign ctrl_o.done   = col_done;
  assign ctrl_o.last   = row_last;
  assign ctrl_o.neuron = fcmac_pkg::NeuronW'(row_q);

endmodule

### rtl/core/fcmac_datapath.sv
// Multiply, accumulate and saturate pipeline with the output register.
module fcmac_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              adv_i,
  input  fcmac_pkg::mac_ctrl_t              ctrl_i,
  input  logic [fcmac_pkg::WeightW-1:0]     weight_i,
  input  logic [fcmac_pkg::DataW-1:0]       act_i,
  output logic                              out_valid_o,
  output logic [fcmac_pkg::DataW-1:0]       out_result_o,
  output logic                              out_sat_o,
  output logic [fcmac_pkg::NeuronW-1:0]     out_neuron_o,
  output logic                              out_last_o
);

  fcmac_pkg::mac_ctrl_t s1_q, s2_q;
  logic [fcmac_pkg::WeightW-1:0] w1_q;
  logic signed [fcmac_pkg::ProdW-1:0] prod_q;
  logic [fcmac_pkg::AccW-1:0] acc_q, sum, fin_q;
  logic fin_valid_q, fin_last_q;
  logic [fcmac_pkg::NeuronW-1:0] fin_neuron_q;
  logic out_valid_q, out_sat_q, out_last_q;
  logic [fcmac_pkg::DataW-1:0] out_result_q;
  logic [fcmac_pkg::NeuronW-1:0] out_neuron_q;
  logic [fcmac_pkg::DataW-1:0] sat_val;
  logic fits, sat_flag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q        <= '0;
      s2_q        <= '0;
      acc_q       <= '0;
      fin_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      s1_q        <= ctrl_i;
      s2_q        <= s1_q;
      fin_valid_q <= s2_q.valid && s2_q.done;
      out_valid_q <= fin_valid_q;
      if (s2_q.valid) begin
        acc_q <= s2_q.done ? '0 : sum;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      w1_q         <= weight_i;
      prod_q       <= $signed(act_i) * $signed(w1_q);
      fin_q        <= sum;
      fin_last_q   <= s2_q.last;
      fin_neuron_q <= s2_q.neuron;
      if (fin_valid_q) begin
        out_result_q <= sat_val;
        out_sat_q    <= sat_flag;
        out_neuron_q <= fin_neuron_q;
        out_last_q   <= fin_last_q;
      end
    end
  end

  assign sum = acc_q + fcmac_pkg::AccW'(prod_q);

  // Fits in int32 when bits 63..31 are all equal
  assign fits     = (fin_q[fcmac_pkg::AccW-1:fcmac_pkg::DataW-1] == '0) ||
                    (fin_q[fcmac_pkg::AccW-1:fcmac_pkg::DataW-1] == '1);
  assign sat_flag = !fits;

  always_comb begin
    if (fits) begin
      sat_val = fin_q[fcmac_pkg::DataW-1:0];
    end else if (fin_q[fcmac_pkg::AccW-1]) begin
      sat_val = {1'b1, {(fcmac_pkg::DataW-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(fcmac_pkg::DataW-1){1'b1}}};
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_result_o = out_result_q;
  assign out_sat_o    = out_sat_q;
  assign out_neuron_o = out_neuron_q;
  assign out_last_o   = out_last_q;

endmodule

### rtl/core/int16_weight_fc_layer_mac.sv
// Top level: fully connected layer MAC with activation store and stream ports.
// Throughput: one item per cycle; loads and weights alike, stalls only on output backpressure.
// A neuron result passes the s1, s2, fin and output registers after its final weight transaction.
// Activation store is a one-port-read, one-port-write memory read at weight acceptance.
// Reset clears positions, accumulator and valids; counts return to 400 and 64.
// Activation store contents are not cleared by reset.
module int16_weight_fc_layer_mac #(
  parameter int unsigned MaxInputs  = fcmac_pkg::MaxInputsDef,
  parameter int unsigned MaxOutputs = fcmac_pkg::MaxOutputsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fcmac_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [fcmac_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [31:0] activation, [63:32] weight_word
  input  logic [fcmac_pkg::InTdataW-1:0]    s_axis_tdata,
  // [0] func
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [31:0] result, [37:32] neuron_index, [39:38] zero
  output logic [fcmac_pkg::OutTdataW-1:0]   m_axis_tdata,
  // [0] saturated
  output logic                              m_axis_tuser,
  output logic                              m_axis_tlast
);

  localparam int unsigned AddrW = (MaxInputs > 1) ? $clog2(MaxInputs) : 1;

  logic adv, accept;
  logic mem_we, mem_re;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [fcmac_pkg::DataW-1:0] act_rdata;
  fcmac_pkg::mac_ctrl_t ctrl;
  logic [fcmac_pkg::DataW-1:0] out_result;
  logic [fcmac_pkg::NeuronW-1:0] out_neuron;

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid && adv;

  fcmac_ctrl #(
    .MaxInputs  (MaxInputs),
    .MaxOutputs (MaxOutputs),
    .AddrW      (AddrW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .func_i      (s_axis_tuser),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .ctrl_o      (ctrl)
  );

  fcmac_act_mem #(
    .Depth (MaxInputs),
    .AddrW (AddrW)
  ) u_act_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (s_axis_tdata[fcmac_pkg::DataW-1:0]),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (act_rdata)
  );

  fcmac_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .ctrl_i       (ctrl),
    .weight_i     (s_axis_tdata[fcmac_pkg::DataW +: fcmac_pkg::WeightW]),
    .act_i        (act_rdata),
    .out_valid_o  (m_axis_tvalid),
    .out_result_o (out_result),
    .out_sat_o    (m_axis_tuser),
    .out_neuron_o (out_neuron),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, out_neuron, out_result};

endmodule

### tb/tb_int16_weight_fc_layer_mac.sv
// Self-checking testbench for the int16-weight fully connected layer MAC.
module tb_int16_weight_fc_layer_mac;
  import fcmac_pkg::*;

  localparam int unsigned SettleCycles = 8;
  localparam int unsigned CycleLimit   = 1_000_000;
  localparam int unsigned ReportLimit  = 10;
  localparam logic signed [AccW-1:0] Int32Max = 64'sd2147483647;
  localparam logic signed [AccW-1:0] Int32Min = -64'sd2147483648;

  typedef struct packed {
    logic             func;
    logic [DataW-1:0] activation;
    logic [DataW-1:0] weight_word;
  } fc_item_t;

  typedef struct packed {
    logic [DataW-1:0]   value;
    logic               saturated;
    logic [NeuronW-1:0] neuron;
    logic               last;
  } neuron_out_t;

  typedef enum logic [1:0] {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_mode_e;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]    cfg_idx_i     = '0;
  logic [CfgDataW-1:0]   cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [InTdataW-1:0]   s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OutTdataW-1:0]  m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;

  int16_weight_fc_layer_mac dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Layer state mirror
  logic [DataW-1:0]       act_mem   [MaxInputsDef];
  bit                     act_valid [MaxInputsDef];
  int unsigned            load_pos       = 0;
  int unsigned            col_pos        = 0;
  int unsigned            row_pos        = 0;
  int unsigned            rows_completed = 0;
  logic signed [AccW-1:0] acc            = '0;
  logic [InCountW-1:0]    in_count_reg   = InCountRst;
  logic [OutCountW-1:0]   out_count_reg  = OutCountRst;

  neuron_out_t pending_neurons[$];
  int unsigned mismatch_count = 0;
  int unsigned clk_cycles     = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  function automatic int unsigned eff_inputs();
    if (in_count_reg == 0) return 1;
    if (in_count_reg > MaxInputsDef) return MaxInputsDef;
    return in_count_reg;
  endfunction

  function automatic int unsigned eff_outputs();
    if (out_count_reg == 0) return 1;
    if (out_count_reg > MaxOutputsDef) return MaxOutputsDef;
    return out_count_reg;
  endfunction

  function automatic void predict_neuron_output(fc_item_t item);
    logic [DataW-1:0]       act;
    logic signed [AccW-1:0] act_ext;
    logic signed [AccW-1:0] wgt_ext;
    neuron_out_t            res;
    if (item.func == FuncLoad) begin
      if (load_pos < MaxInputsDef) begin
        act_mem[load_pos]   = item.activation;
        act_valid[load_pos] = 1'b1;
      end
      load_pos++;
      if (load_pos >= eff_inputs()) load_pos = 0;
      return;
    end
    act     = (col_pos < MaxInputsDef) ? act_mem[col_pos] : '0;
    act_ext = $signed(act);
    wgt_ext = $signed(item.weight_word[WeightW-1:0]);
    acc     = acc + act_ext * wgt_ext;
    col_pos++;
    if (col_pos < eff_inputs()) return;
    res.saturated = 1'b0;
    if (acc > Int32Max) begin
      res.value     = 32'h7FFF_FFFF;
      res.saturated = 1'b1;
    end else if (acc < Int32Min) begin
      res.value     = 32'h8000_0000;
      res.saturated = 1'b1;
    end else begin
      res.value = acc[DataW-1:0];
    end
    res.neuron = row_pos[NeuronW-1:0];
    res.last   = (row_pos + 1 >= eff_outputs());
    pending_neurons.push_back(res);
    acc     = '0;
    col_pos = 0;
    row_pos = res.last ? 0 : row_pos + 1;
    rows_completed++;
  endfunction

  function automatic logic [DataW-1:0] rand_act();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'(int'($urandom_range(512)) - 256);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [WeightW-1:0] rand_weight();
    case ($urandom_range(6))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'hFFFF;
      3: return 16'(int'($urandom_range(64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  // A weight is only issued when its activation has been loaded
  function automatic fc_item_t make_item(bit want_weight);
    fc_item_t item;
    item.activation              = rand_act();
    item.weight_word             = $urandom;
    item.weight_word[WeightW-1:0] = rand_weight();
    if (want_weight && (col_pos >= MaxInputsDef || act_valid[col_pos]))
      item.func = FuncWeight;
    else
      item.func = FuncLoad;
    return item;
  endfunction

  function automatic void note_mismatch(string what, neuron_out_t want, neuron_out_t got);
    mismatch_count++;
    if (mismatch_count <= ReportLimit)
      $display("%s: want value %h sat %b neuron %0d last %b, got value %h sat %b neuron %0d last %b",
               what, want.value, want.saturated, want.neuron, want.last,
               got.value, got.saturated, got.neuron, got.last);
  endfunction

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin : check_results
    neuron_out_t want;
    neuron_out_t got;
    clk_cycles++;
    if (clk_cycles >= CycleLimit) begin
      $display("int16_weight_fc_layer_mac: mismatch");
      $finish;
    end else if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.value     = m_axis_tdata[DataW-1:0];
      got.saturated = m_axis_tuser;
      got.neuron    = m_axis_tdata[DataW +: NeuronW];
      got.last      = m_axis_tlast;
      if (pending_neurons.size() == 0) begin
        note_mismatch("result with none pending", '0, got);
      end else begin
        want = pending_neurons.pop_front();
        if (got.value != want.value || got.saturated != want.saturated ||
            got.neuron != want.neuron || got.last != want.last)
          note_mismatch("neuron result", want, got);
      end
    end
  end

  task automatic send_item(fc_item_t item);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {item.weight_word, item.activation};
    s_axis_tuser  <= item.func;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_neuron_output(item);
  endtask

  task automatic send_load(logic [DataW-1:0] act);
    fc_item_t item;
    item.func        = FuncLoad;
    item.activation  = act;
    item.weight_word = $urandom;
    send_item(item);
  endtask

  task automatic send_weight(logic [WeightW-1:0] wgt);
    fc_item_t item;
    item.func        = FuncWeight;
    item.activation  = $urandom;
    item.weight_word = {16'($urandom), wgt};
    send_item(item);
  endtask

  task automatic complete_rows(int unsigned rows);
    int unsigned target;
    target = rows_completed + rows;
    while (rows_completed < target) send_item(make_item(1'b1));
  endtask

  task automatic random_traffic(int unsigned n_items, int unsigned weight_pct);
    repeat (n_items) send_item(make_item($urandom_range(99) < weight_pct));
    while (col_pos != 0) send_item(make_item(1'b1));
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_neurons.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    if (idx == RegInputCount) in_count_reg = data[InCountW-1:0];
    else out_count_reg = data[OutCountW-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic configure(int unsigned in_count, int unsigned out_count);
    wait_idle();
    write_reg(RegInputCount, CfgDataW'(in_count));
    write_reg(RegOutputCount, CfgDataW'(out_count));
  endtask

  task automatic set_idling(idle_mode_e mode);
    case (mode)
      IdleNone:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IdleSender:   begin send_idle_pct = 85; recv_stall_pct = 0;  end
      IdleReceiver: begin send_idle_pct = 0;  recv_stall_pct = 85; end
      default:      begin send_idle_pct = 11; recv_stall_pct = 11; end
    endcase
  endtask

  // Default counts of 400 inputs and 64 neurons
  task automatic test_reset_counts();
    set_idling(IdleNone);
    repeat (int'(InCountRst) + 1) send_load(rand_act());
    wait_idle();
    write_reg(RegInputCount, CfgDataW'(1));
    complete_rows(int'(OutCountRst) + 1);
  endtask

  task automatic test_saturation_edges();
    set_idling(IdleReceiver);
    configure(1, 3);
    send_load(32'h7FFF_FFFF);
    send_weight(16'h0001);
    send_weight(16'h7FFF);
    send_load(32'h8000_0000);
    send_weight(16'h0001);
    send_weight(16'hFFFF);
    send_weight(16'h7FFF);
    send_weight(16'h8000);
    send_weight(16'h0000);
    send_load(32'hFFFF_FFFF);
    send_weight(16'h8000);
    // one past the int32 limits over two columns
    configure(2, 3);
    send_load(32'h7FFF_FFFF);
    send_load(32'h0000_0001);
    send_weight(16'h0001);
    send_weight(16'h0001);
    send_load(32'h8000_0000);
    send_load(32'hFFFF_FFFF);
    send_weight(16'h0001);
    send_weight(16'h0001);
    // zero counts act as one
    configure(0, 0);
    send_load(32'h1234_5678);
    send_weight(16'h0002);
    send_weight(16'hFFFE);
  endtask

  task automatic test_midpass_reconfig();
    set_idling(IdleSender);
    configure(8, 8);
    while (row_pos != 5) complete_rows(1);
    while (col_pos != 5) send_item(make_item(1'b1));
    while (load_pos != 6) send_load(rand_act());
    // column and row now sit past the new counts
    configure(3, 2);
    send_weight(rand_weight());
    send_load(rand_act());
    random_traffic(20, 70);
  endtask

  task automatic test_wide_layer();
    set_idling(IdleBoth);
    configure(1023, MaxOutputsDef);
    do send_load(rand_act()); while (load_pos != 0);
    send_load(rand_act());
    configure(1, MaxOutputsDef);
    complete_rows(1);
  endtask

  task automatic test_neuron_wrap();
    set_idling(IdleReceiver);
    configure(1, 127);
    complete_rows(70);
  endtask

  task automatic test_random_layers();
    int unsigned n_in;
    int unsigned n_out;
    for (int p = 0; p < 4; p++) begin
      set_idling(idle_mode_e'(p % 4));
      case ($urandom_range(3))
        0: n_in = $urandom_range(0, 2);
        default: n_in = $urandom_range(1, 12);
      endcase
      case ($urandom_range(3))
        0: n_out = $urandom_range(65, 127);
        1: n_out = $urandom_range(0, 1);
        default: n_out = $urandom_range(1, 8);
      endcase
      configure(n_in, n_out);
      random_traffic(30, 70);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_counts();
    test_saturation_edges();
    test_midpass_reconfig();
    test_wide_layer();
    test_neuron_wrap();
    test_random_layers();

    set_idling(IdleNone);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    for (int i = 0; i < 2000 && pending_neurons.size() != 0; i++) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (pending_neurons.size() != 0) begin
      $display("%0d neuron results never arrived", pending_neurons.size());
      mismatch_count += pending_neurons.size();
    end
    if (mismatch_count == 0) begin
      $display("int16_weight_fc_layer_mac: match");
    end else begin
      $display("int16_weight_fc_layer_mac: mismatch");
    end
    $finish;
  end

endmodule
